// File: sv/mmc3m_pkg.sv
// ----------------------------------------------------------------------------
// mmc3m_pkg
// Types and constants shared by the bank and irq mapper modules.
// ----------------------------------------------------------------------------
package mmc3m_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_PRG   = 2'd2,
    MODE_CHR   = 2'd3
  } mode_t;

  // register decode on cpu address
  localparam logic [15:0] REG_MASK        = 16'hE001;
  localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
  localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
  localparam logic [15:0] REG_MIRROR      = 16'hA000;
  localparam logic [15:0] REG_IRQ_COUNT   = 16'hC000;
  localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC001;
  localparam logic [15:0] REG_IRQ_DISABLE = 16'hE000;
  localparam logic [15:0] REG_IRQ_ENABLE  = 16'hE001;

  localparam logic [7:0] PRG_RESET_2    = 8'h3e;
  localparam logic [7:0] PRG_RESET_3    = 8'h3f;
  localparam logic [7:0] CHR_PAIR_MASK  = 8'hFE;
  localparam logic [8:0] LAST_VISIBLE   = 9'd239;
  localparam logic [1:0] MIRROR_SINGLE_HI = 2'd3;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] cpu_addr;
    logic [12:0] ppu_addr;
    logic [7:0]  write_data;
    logic [8:0]  scanline_number;
    logic        display_on;
  } item_t;

  typedef struct packed {
    logic [7:0] prg_bank;
    logic [7:0] chr_bank;
    logic       chr_is_ram;
    logic [1:0] mirroring;
    logic       irq_line;
  } result_t;

endpackage

// File: sv/mmc3_style_bank_and_irq_mapper_top.sv
// ----------------------------------------------------------------------------
// mmc3_style_bank_and_irq_mapper_top
// Cartridge bank mapper with scanline irq counter, one result per item.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_ready    mode cpu_addr ppu_addr write_data
//                                scanline_number display_on
//  out      out_valid/out_ready  prg_bank chr_bank chr_is_ram mirroring irq_line
//
//  one item per cycle sustained while out_ready is high; a result is valid once its item
//  leaves the input register (which feeds the state update) for the result register
//  the input register takes one more item while a result waits to be taken
//  synchronous reset restores all bank and irq registers
//  in_ready drops only when both registers hold an item and out_ready is low
module mmc3_style_bank_and_irq_mapper_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [15:0] cpu_addr,
  input  logic [12:0] ppu_addr,
  input  logic [7:0]  write_data,
  input  logic [8:0]  scanline_number,
  input  logic        display_on,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  prg_bank,
  output logic [7:0]  chr_bank,
  output logic        chr_is_ram,
  output logic [1:0]  mirroring,
  output logic        irq_line
);
  import mmc3m_pkg::*;

  logic    s1_valid;
  item_t   s1_item;
  logic    advance;
  result_t core_res;
  result_t out_res;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.mode            <= mode_t'(mode);
      s1_item.cpu_addr        <= cpu_addr;
      s1_item.ppu_addr        <= ppu_addr;
      s1_item.write_data      <= write_data;
      s1_item.scanline_number <= scanline_number;
      s1_item.display_on      <= display_on;
    end
  end

  mmc3m_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (s1_item),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= core_res;
  end

  assign prg_bank   = out_res.prg_bank;
  assign chr_bank   = out_res.chr_bank;
  assign chr_is_ram = out_res.chr_is_ram;
  assign mirroring  = out_res.mirroring;
  assign irq_line   = out_res.irq_line;

endmodule

// File: sv/mmc3m_core.sv
// ----------------------------------------------------------------------------
// mmc3m_core
// Mapper state: bank registers, mirroring and scanline irq counter. Applies
// one item when fire is high and gives the result seen after that item.
// ----------------------------------------------------------------------------
module mmc3m_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  mmc3m_pkg::item_t item,
  output mmc3m_pkg::result_t res
);
  import mmc3m_pkg::*;

  logic [7:0] bank_select, bank_select_next;
  logic [7:0] chr_banks [8];
  logic [7:0] chr_banks_next [8];
  logic [7:0] prg_banks [4];
  logic [7:0] prg_banks_next [4];
  logic [1:0] mirror_mode, mirror_mode_next;
  logic [7:0] irq_count, irq_count_next;
  logic [7:0] irq_reload, irq_reload_next;
  logic       irq_enabled, irq_enabled_next;
  logic       irq_pending, irq_pending_next;
  logic       irq_out, irq_out_next;

  logic [3:0]  sel;
  logic [7:0]  pair_lo;
  logic [7:0]  cnt;
  logic [1:0]  prg_slot;
  logic [2:0]  chr_slot;
  logic [7:0]  chr_val;

  assign sel      = bank_select[3:0];
  assign pair_lo  = item.write_data & CHR_PAIR_MASK;

  always_comb begin
    bank_select_next = bank_select;
    chr_banks_next   = chr_banks;
    prg_banks_next   = prg_banks;
    mirror_mode_next = mirror_mode;
    irq_count_next   = irq_count;
    irq_reload_next  = irq_reload;
    irq_enabled_next = irq_enabled;
    irq_pending_next = irq_pending;
    irq_out_next     = irq_out;
    cnt              = irq_count;

    case (item.mode)
      MODE_WRITE: begin
        case (item.cpu_addr & REG_MASK)
          REG_BANK_SELECT: bank_select_next = item.write_data;
          REG_BANK_DATA: begin
            if (sel == 4'd0) begin
              chr_banks_next[0] = pair_lo;
              chr_banks_next[1] = pair_lo | 8'd1;
            end else if (sel == 4'd1) begin
              chr_banks_next[2] = pair_lo;
              chr_banks_next[3] = pair_lo | 8'd1;
            end else if (sel inside {[4'd2:4'd5]}) begin
              chr_banks_next[sel[2:0] + 3'd2] = item.write_data;
            end else if (sel inside {[4'd6:4'd9]}) begin
              prg_banks_next[2'(sel - 4'd6)] = item.write_data;
            end
          end
          REG_MIRROR: begin
            mirror_mode_next = (item.write_data < 8'd3) ? item.write_data[1:0]
                                                        : MIRROR_SINGLE_HI;
          end
          REG_IRQ_COUNT: begin
            irq_count_next   = item.write_data;
            irq_pending_next = 1'b0;
          end
          REG_IRQ_RELOAD: begin
            irq_reload_next  = item.write_data;
            irq_pending_next = 1'b0;
          end
          REG_IRQ_DISABLE: begin
            irq_enabled_next = 1'b0;
            irq_pending_next = 1'b0;
            irq_out_next     = 1'b0;
          end
          REG_IRQ_ENABLE: begin
            irq_enabled_next = 1'b1;
            irq_pending_next = 1'b0;
          end
          default: ;
        endcase
      end
      MODE_TICK: begin
        if (item.scanline_number <= LAST_VISIBLE && item.display_on &&
            irq_enabled && !irq_pending) begin
          // first visible line takes one extra decrement
          if (item.scanline_number == 9'd0 && cnt != 8'd0) cnt = cnt - 8'd1;
          if (cnt == 8'd0) begin
            irq_pending_next = 1'b1;
            irq_out_next     = 1'b1;
            irq_count_next   = irq_reload;
          end else begin
            irq_count_next = cnt - 8'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // translation, slots 0 and 2 swap with select bit 6, chr halves with bit 7
  always_comb begin
    prg_slot = item.cpu_addr[14:13];
    if (bank_select[6] && !prg_slot[0]) prg_slot = prg_slot ^ 2'd2;
    chr_slot = item.ppu_addr[12:10];
    if (bank_select[7]) chr_slot = chr_slot ^ 3'd4;
    chr_val = chr_banks[chr_slot];

    res            = '0;
    res.mirroring  = mirror_mode_next;
    res.irq_line   = irq_out_next;
    if (item.mode == MODE_PRG) begin
      res.prg_bank = prg_banks[prg_slot];
    end else if (item.mode == MODE_CHR) begin
      res.chr_bank   = chr_val;
      res.chr_is_ram = (chr_val <= 8'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select  <= '0;
      for (int i = 0; i < 8; i++) chr_banks[i] <= 8'(i);
      prg_banks[0] <= 8'h00;
      prg_banks[1] <= 8'h01;
      prg_banks[2] <= PRG_RESET_2;
      prg_banks[3] <= PRG_RESET_3;
      mirror_mode  <= '0;
      irq_count    <= '0;
      irq_reload   <= '0;
      irq_enabled  <= 1'b0;
      irq_pending  <= 1'b0;
      irq_out      <= 1'b0;
    end else if (fire) begin
      bank_select  <= bank_select_next;
      chr_banks    <= chr_banks_next;
      prg_banks    <= prg_banks_next;
      mirror_mode  <= mirror_mode_next;
      irq_count    <= irq_count_next;
      irq_reload   <= irq_reload_next;
      irq_enabled  <= irq_enabled_next;
      irq_pending  <= irq_pending_next;
      irq_out      <= irq_out_next;
    end
  end

endmodule

// File: sv/mmc3m_checker.sv
// ----------------------------------------------------------------------------
// mmc3m_checker
// Port-level checks on the mapper top, attached by bind.
// ----------------------------------------------------------------------------
module mmc3m_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  prg_bank,
  input logic [7:0]  chr_bank,
  input logic        chr_is_ram,
  input logic [1:0]  mirroring,
  input logic        irq_line
);

  // no result straight out of reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with no waiting result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(prg_bank) &&
    $stable(chr_bank) && $stable(chr_is_ram) && $stable(mirroring) &&
    $stable(irq_line))
    else $error("stalled item changed");

  // chr ram flag matches the bank it reports
  a_ram_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && chr_is_ram |-> chr_bank <= 8'd1)
    else $error("chr ram flag on a rom bank");

  // an item is either a prg or a chr lookup, never both
  a_one_lookup: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(prg_bank != 8'd0 && (chr_bank != 8'd0 || chr_is_ram)))
    else $error("prg and chr result in one item");

endmodule

bind mmc3_style_bank_and_irq_mapper_top mmc3m_checker u_mmc3m_checker (.*);

// File: tb/sv/mmc3_style_bank_and_irq_mapper_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc3_style_bank_and_irq_mapper_top_test
// Drives register writes, scanline ticks and prg/chr translations into the
// mapper, random idle cycles on both channels but in one steady phase. A
// scoreboard keeps a copy of the bank and irq state, predicts and checks each result.
// ----------------------------------------------------------------------------
package mapper_tb_pkg;
  import mmc3m_pkg::*;

  // bank select index codes, bits 3..0 of the bank select register
  localparam logic [3:0] SEL_CHR_PAIR_0 = 4'd0;
  localparam logic [3:0] SEL_CHR_PAIR_1 = 4'd1;
  localparam logic [3:0] SEL_CHR_LAST   = 4'd5;
  localparam logic [3:0] SEL_PRG_FIRST  = 4'd6;
  localparam logic [3:0] SEL_PRG_LAST   = 4'd9;

  class mapper_scoreboard;
    logic [7:0] bank_sel;
    logic [7:0] chr_map [8];
    logic [7:0] prg_map [4];
    logic [1:0] mirror;
    logic [7:0] irq_cnt;
    logic [7:0] irq_reload_val;
    logic       irq_en;
    logic       irq_pend;
    logic       irq_out_q;
    result_t    expected_results [$];
    int         errors;

    function new();
      errors = 0;
      reset_state();
    endfunction

    function void reset_state();
      bank_sel = '0;
      for (int i = 0; i < 8; i++) chr_map[i] = 8'(i);
      prg_map[0] = 8'h00;
      prg_map[1] = 8'h01;
      prg_map[2] = PRG_RESET_2;
      prg_map[3] = PRG_RESET_3;
      mirror = '0;
      irq_cnt = '0;
      irq_reload_val = '0;
      irq_en = 1'b0;
      irq_pend = 1'b0;
      irq_out_q = 1'b0;
      expected_results.delete();
    endfunction

    function void apply_write(logic [15:0] addr, logic [7:0] data);
      logic [3:0] sel;
      sel = bank_sel[3:0];
      case (addr & REG_MASK)
        REG_BANK_SELECT: bank_sel = data;
        REG_BANK_DATA: begin
          if (sel == SEL_CHR_PAIR_0) begin
            chr_map[0] = data & CHR_PAIR_MASK;
            chr_map[1] = (data & CHR_PAIR_MASK) | 8'd1;
          end else if (sel == SEL_CHR_PAIR_1) begin
            chr_map[2] = data & CHR_PAIR_MASK;
            chr_map[3] = (data & CHR_PAIR_MASK) | 8'd1;
          end else if (sel <= SEL_CHR_LAST) begin
            chr_map[3'(sel + 4'd2)] = data;
          end else if (sel <= SEL_PRG_LAST) begin
            prg_map[2'(sel - SEL_PRG_FIRST)] = data;
          end
        end
        REG_MIRROR: mirror = (data < 8'(MIRROR_SINGLE_HI)) ? data[1:0] : MIRROR_SINGLE_HI;
        REG_IRQ_COUNT: begin
          irq_cnt = data;
          irq_pend = 1'b0;
        end
        REG_IRQ_RELOAD: begin
          irq_reload_val = data;
          irq_pend = 1'b0;
        end
        REG_IRQ_DISABLE: begin
          irq_en = 1'b0;
          irq_pend = 1'b0;
          irq_out_q = 1'b0;
        end
        REG_IRQ_ENABLE: begin
          irq_en = 1'b1;
          irq_pend = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void run_scanline(logic [8:0] line, logic disp);
      if (line > LAST_VISIBLE || !disp || !irq_en || irq_pend) return;
      // line 0 takes one extra decrement before the zero test
      if (line == 9'd0 && irq_cnt != 8'd0) irq_cnt = irq_cnt - 8'd1;
      if (irq_cnt == 8'd0) begin
        irq_pend = 1'b1;
        irq_out_q = 1'b1;
        irq_cnt = irq_reload_val;
      end else begin
        irq_cnt = irq_cnt - 8'd1;
      end
    endfunction

    function void note_item(item_t it);
      result_t    exp;
      logic [1:0] pslot;
      logic [2:0] cslot;
      exp = '0;
      case (it.mode)
        MODE_WRITE: apply_write(it.cpu_addr, it.write_data);
        MODE_TICK:  run_scanline(it.scanline_number, it.display_on);
        MODE_PRG: begin
          pslot = it.cpu_addr[14:13];
          if (bank_sel[6] && !pslot[0]) pslot = pslot ^ 2'd2;
          exp.prg_bank = prg_map[pslot];
        end
        default: begin
          cslot = it.ppu_addr[12:10];
          if (bank_sel[7]) cslot = cslot ^ 3'd4;
          exp.chr_bank = chr_map[cslot];
          exp.chr_is_ram = (chr_map[cslot] <= 8'd1);
        end
      endcase
      exp.mirroring = mirror;
      exp.irq_line = irq_out_q;
      expected_results.push_back(exp);
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $time, got);
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      compare_field("prg_bank", exp.prg_bank, got.prg_bank);
      compare_field("chr_bank", exp.chr_bank, got.chr_bank);
      compare_field("chr_is_ram", exp.chr_is_ram, got.chr_is_ram);
      compare_field("mirroring", exp.mirroring, got.mirroring);
      compare_field("irq_line", exp.irq_line, got.irq_line);
    endfunction
  endclass
endpackage

module mmc3_style_bank_and_irq_mapper_top_test;
  import mmc3m_pkg::*;
  import mapper_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 4;
  localparam int PHASE_ITEMS  = 175;
  localparam int TAIL_CYCLES  = 10;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [15:0] cpu_addr;
  logic [12:0] ppu_addr;
  logic [7:0]  write_data;
  logic [8:0]  scanline_number;
  logic        display_on;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  prg_bank;
  logic [7:0]  chr_bank;
  logic        chr_is_ram;
  logic [1:0]  mirroring;
  logic        irq_line;

  logic             steady;
  mapper_scoreboard sb;

  mmc3_style_bank_and_irq_mapper_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .cpu_addr(cpu_addr), .ppu_addr(ppu_addr),
    .write_data(write_data), .scanline_number(scanline_number),
    .display_on(display_on),
    .out_valid(out_valid), .out_ready(out_ready),
    .prg_bank(prg_bank), .chr_bank(chr_bank), .chr_is_ram(chr_is_ram),
    .mirroring(mirroring), .irq_line(irq_line)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** mmc3_style_bank_and_irq_mapper_top: FAILED **");
    $finish;
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic item_t make_item(mode_t m, logic [15:0] ca, logic [12:0] pa,
                                      logic [7:0] wd, logic [8:0] line, logic disp);
    item_t it;
    it.mode = m;
    it.cpu_addr = ca;
    it.ppu_addr = pa;
    it.write_data = wd;
    it.scanline_number = line;
    it.display_on = disp;
    return it;
  endfunction

  // mostly decoded register writes and visible-line ticks so the irq counter fires
  function automatic item_t random_item();
    item_t       it;
    int          pick;
    logic [15:0] reg_addr;
    it.mode = mode_t'($urandom_range(0, 3));
    it.cpu_addr = 16'($urandom);
    it.ppu_addr = 13'($urandom);
    it.write_data = 8'($urandom);
    it.scanline_number = 9'($urandom);
    it.display_on = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      it.mode = MODE_WRITE;
      case ($urandom_range(0, 9))
        0:       reg_addr = REG_BANK_SELECT;
        1, 2:    reg_addr = REG_BANK_DATA;
        3:       reg_addr = REG_MIRROR;
        4:       reg_addr = REG_IRQ_COUNT;
        5:       reg_addr = REG_IRQ_RELOAD;
        6:       reg_addr = REG_IRQ_DISABLE;
        default: reg_addr = REG_IRQ_ENABLE;
      endcase
      it.cpu_addr = (it.cpu_addr & ~REG_MASK) | reg_addr;
      if ((reg_addr == REG_IRQ_COUNT || reg_addr == REG_IRQ_RELOAD) &&
          $urandom_range(0, 3) != 0)
        it.write_data = 8'($urandom_range(0, 6));
    end else if (pick < 40) begin
      it.mode = MODE_WRITE;
    end else if (pick < 68) begin
      it.mode = MODE_TICK;
      if ($urandom_range(0, 6) != 0) begin
        it.scanline_number = 9'($urandom_range(0, 239));
        if ($urandom_range(0, 3) == 0) it.scanline_number = '0;
      end
      it.display_on = ($urandom_range(0, 9) != 0);
    end else if (pick < 84) begin
      it.mode = MODE_PRG;
    end else begin
      it.mode = MODE_CHR;
    end
    return it;
  endfunction

  task automatic send_item(item_t it, int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode = it.mode;
    cpu_addr = it.cpu_addr;
    ppu_addr = it.ppu_addr;
    write_data = it.write_data;
    scanline_number = it.scanline_number;
    display_on = it.display_on;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    item_t   seen;
    result_t got;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen.mode = mode_t'(mode);
        seen.cpu_addr = cpu_addr;
        seen.ppu_addr = ppu_addr;
        seen.write_data = write_data;
        seen.scanline_number = scanline_number;
        seen.display_on = display_on;
        sb.note_item(seen);
      end
      if (out_valid && out_ready) begin
        got.prg_bank = prg_bank;
        got.chr_bank = chr_bank;
        got.chr_is_ram = chr_is_ram;
        got.mirroring = mirroring;
        got.irq_line = irq_line;
        sb.check_result(got);
      end
    end
  end

  // result side: random stall before each result, none in the steady phase
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    item_t directed [$];
    rst = 1'b1;
    in_valid = 1'b0;
    mode = '0;
    cpu_addr = '0;
    ppu_addr = '0;
    write_data = '0;
    scanline_number = '0;
    display_on = 1'b0;
    steady = 1'b0;
    sb = new();
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // reset banks, then swap modes, pair writes, ignored writes, irq fire
    directed.push_back(make_item(MODE_PRG, 16'h8000, 13'h0000, 8'h00, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_PRG, 16'hA000, 13'h0000, 8'h00, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_PRG, 16'hC000, 13'h0000, 8'h00, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_PRG, 16'hFFFF, 13'h0000, 8'h00, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_PRG, 16'h7FFF, 13'h0000, 8'h00, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_CHR, 16'h0000, 13'h0000, 8'h00, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_CHR, 16'h0000, 13'h1FFF, 8'h00, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_WRITE, REG_BANK_SELECT, 13'h0, 8'hFF, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_WRITE, REG_BANK_DATA, 13'h0, 8'hFF, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_PRG, 16'h8000, 13'h0000, 8'h00, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_CHR, 16'h0000, 13'h0000, 8'h00, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_WRITE, REG_BANK_SELECT, 13'h0, 8'h00, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_WRITE, REG_BANK_DATA, 13'h0, 8'hFF, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_CHR, 16'h0000, 13'h0400, 8'h00, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_WRITE, REG_BANK_SELECT, 13'h0, 8'h09, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_WRITE, REG_BANK_DATA, 13'h0, 8'hFF, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_PRG, 16'hE000, 13'h0000, 8'h00, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_WRITE, REG_MIRROR, 13'h0, 8'hFF, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_WRITE, 16'hA001, 13'h0, 8'h00, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_WRITE, 16'h6000, 13'h0, 8'h01, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_WRITE, REG_IRQ_RELOAD, 13'h0, 8'h01, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_WRITE, REG_IRQ_COUNT, 13'h0, 8'h00, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_WRITE, REG_IRQ_ENABLE, 13'h0, 8'h00, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_TICK, 16'h0000, 13'h0, 8'h00, 9'd0, 1'b1));
    directed.push_back(make_item(MODE_TICK, 16'h0000, 13'h0, 8'h00, 9'd511, 1'b1));
    directed.push_back(make_item(MODE_TICK, 16'h0000, 13'h0, 8'h00, 9'd10, 1'b0));
    directed.push_back(make_item(MODE_WRITE, REG_IRQ_DISABLE, 13'h0, 8'h00, 9'd0, 1'b0));
    directed.push_back(make_item(MODE_TICK, 16'h0000, 13'h0, 8'h00, 9'd239, 1'b1));

    foreach (directed[i]) send_item(directed[i], draw_gap());
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      steady = (phase == 1);
      for (int k = 0; k < PHASE_ITEMS; k++) send_item(random_item(), draw_gap());
      // hold the sender until every result is back
      drain();
    end
    steady = 1'b0;

    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("** mmc3_style_bank_and_irq_mapper_top: PASSED **");
    end else begin
      $display("** mmc3_style_bank_and_irq_mapper_top: FAILED **");
    end
    $finish;
  end

endmodule
